// ===== rtl/core/wildcard_byte_pattern_search_core_macros.svh =====
// Assertion macros shared by the wildcard byte pattern search RTL.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_CORE_MACROS_SVH

// Check an implication on every rising clk edge, off while rst_n is low.
`define WBPS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clk edge out of reset.
`define WBPS_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== rtl/core/wbps_pkg.sv =====
// Package with types and constants of the wildcard byte pattern search core.
package wbps_pkg;

  localparam int MaxPatternDef = 128;
  localparam logic [7:0] WildcardByte = 8'h3F;
  localparam int DataW = 8;
  localparam int IdxW = 7;
  localparam int OffsetW = 32;
  localparam int LenCfgW = 8;

  typedef enum logic {
    FUNC_LOAD = 1'b0,
    FUNC_SCAN = 1'b1
  } func_t;

  // Per-item command from the control path to the cell array.
  typedef struct packed {
    logic            load;
    logic            scan;
    logic            clear;
    logic [IdxW-1:0] idx;
    logic [DataW-1:0] data;
  } wbps_cell_ctrl_t;

endpackage

// ===== rtl/core/wbps_cell_array.sv =====
// Pattern cells: stored pattern bytes, partial-match bits and the full-match detect.
module wbps_cell_array import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MaxPatternDef
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  wbps_cell_ctrl_t        ctrl,
  input  logic [MAX_PATTERN-1:0] len_mask,
  output logic                   match
);

  logic [DataW-1:0]       store_r [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] bits_r;
  logic [MAX_PATTERN-1:0] bits_nxt;
  logic [MAX_PATTERN:0]   prev_vec;
  logic [MAX_PATTERN-1:0] hit;
  logic [MAX_PATTERN-1:0] upd;

  // Cell i extends the run that cell i-1 held on the previous byte.
  always_comb begin
    prev_vec = {bits_r, 1'b1};
    for (int i = 0; i < MAX_PATTERN; i++) begin
      hit[i] = (store_r[i] == WildcardByte) || (store_r[i] == ctrl.data);
    end
    upd   = prev_vec[MAX_PATTERN-1:0] & hit;
    match = |(upd & len_mask);
    if (ctrl.clear) begin
      bits_nxt = '0;
    end else if (ctrl.scan) begin
      bits_nxt = upd;
    end else begin
      bits_nxt = bits_r;
    end
  end

  // Pattern bytes carry no reset; an out-of-range index matches no cell.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if (ctrl.load && (32'(ctrl.idx) == i)) begin
        store_r[i] <= ctrl.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= '0;
    end else begin
      bits_r <= bits_nxt;
    end
  end

endmodule

// ===== rtl/core/wildcard_byte_pattern_search_core.sv =====
// A result is registered when the input register passes on the scan byte that causes it.
// Throughput: one item per cycle; every pattern cell updates in parallel on each scanned byte,
// but the input register advances only while the result register is empty or being drained.
// Reset (rst_n low, synchronous): clears partial-match bits, byte count, done flag and valids,
// sets the pattern length to 1; pattern bytes stay undefined until loaded.
`include "wildcard_byte_pattern_search_core_macros.svh"
module wildcard_byte_pattern_search_core import wbps_pkg::*; #(
  parameter int MAX_PATTERN = MaxPatternDef
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input stream.
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // [7:0] data_byte, [14:8] pattern_index, [15] zero
  input  logic               in_tuser,   // [0] func
  input  logic               in_tlast,   // last_byte
  // Result stream.
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [OffsetW-1:0] out_tdata,  // [31:0] match_offset
  output logic               out_tuser,  // [0] found
  // Configuration: pattern_length.
  input  logic               cfg_wr_en,
  input  logic [LenCfgW-1:0] cfg_wr_data
);

  localparam int LenW = $clog2(MAX_PATTERN + 1);

  // Input register.
  logic             s1_valid_r, s1_valid_nxt;
  func_t            s1_func_r;
  logic [DataW-1:0] s1_data_r;
  logic [IdxW-1:0]  s1_idx_r;
  logic             s1_last_r;

  // Scan state.
  logic [OffsetW-1:0]     bytes_seen_r, bytes_seen_nxt;
  logic                   done_r, done_nxt;
  logic [LenW-1:0]        len_r, len_nxt;
  logic [MAX_PATTERN-1:0] mask_r, mask_nxt;

  // Result register.
  logic               out_valid_r, out_valid_nxt;
  logic               out_found_r;
  logic [OffsetW-1:0] out_offset_r;

  logic            s1_fire;
  logic            scan_en;
  logic            region_end;
  logic            match;
  logic            res_valid;
  wbps_cell_ctrl_t cell_ctrl;

  // Advance the input register only when the result register can take a transfer.
  assign s1_fire   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_fire;

  // Scan only until a match is reported; the region end clears state regardless.
  assign scan_en    = s1_fire && (s1_func_r == FUNC_SCAN) && !done_r;
  assign region_end = s1_fire && (s1_func_r == FUNC_SCAN) && s1_last_r;
  assign res_valid  = scan_en && (match || s1_last_r);

  always_comb begin
    cell_ctrl.load  = s1_fire && (s1_func_r == FUNC_LOAD);
    cell_ctrl.scan  = scan_en;
    cell_ctrl.clear = region_end;
    cell_ctrl.idx   = s1_idx_r;
    cell_ctrl.data  = s1_data_r;
  end

  wbps_cell_array #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cells (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (cell_ctrl),
    .len_mask(mask_r),
    .match   (match)
  );

  // Clamp the written length to 1..MAX_PATTERN and decode the cell that signals a full match.
  always_comb begin
    len_nxt  = len_r;
    mask_nxt = mask_r;
    if (cfg_wr_en) begin
      if (cfg_wr_data == '0) begin
        len_nxt = LenW'(1);
      end else if (32'(cfg_wr_data) > 32'(MAX_PATTERN)) begin
        len_nxt = LenW'(MAX_PATTERN);
      end else begin
        len_nxt = LenW'(cfg_wr_data);
      end
      for (int i = 0; i < MAX_PATTERN; i++) begin
        mask_nxt[i] = (len_nxt == LenW'(i + 1));
      end
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_tvalid && in_tready) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end

    bytes_seen_nxt = bytes_seen_r;
    done_nxt       = done_r;
    if (region_end) begin
      bytes_seen_nxt = '0;
      done_nxt       = 1'b0;
    end else if (scan_en) begin
      bytes_seen_nxt = bytes_seen_r + OffsetW'(1);
      done_nxt       = match;
    end

    // Hold a pending result until it is taken.
    out_valid_nxt = out_valid_r;
    if (res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      bytes_seen_r <= '0;
      done_r       <= 1'b0;
      len_r        <= LenW'(1);
      mask_r       <= MAX_PATTERN'(1);
      out_valid_r  <= 1'b0;
    end else begin
      s1_valid_r   <= s1_valid_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      done_r       <= done_nxt;
      len_r        <= len_nxt;
      mask_r       <= mask_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: capture on transfer, no reset.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_func_r <= func_t'(in_tuser);
      s1_data_r <= in_tdata[7:0];
      s1_idx_r  <= in_tdata[14:8];
      s1_last_r <= in_tlast;
    end
    if (res_valid) begin
      out_found_r  <= match;
      // The match ends on this byte, so it starts len-1 bytes back.
      out_offset_r <= match ? (bytes_seen_r + OffsetW'(1) - OffsetW'(len_r)) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_offset_r;
  assign out_tuser  = out_found_r;

  `WBPS_ASSERT(a_done_with_found, $rose(done_r) |-> (out_valid_r && out_tuser), "done set without a found result")
  `WBPS_ASSERT(a_region_end_clears, region_end |=> (bytes_seen_r == '0 && !done_r), "region end did not clear scan state")
  `WBPS_NEVER(a_notfound_offset, out_valid_r && !out_tuser && (out_tdata != '0), "not-found result with nonzero offset")

endmodule
